// ===== rtl/core/gnc_pkg.sv =====
// ----------------------------------------------------------------------------
// gnc_pkg
// Shared types and constants of the grid neighbor count block.
// ----------------------------------------------------------------------------
package gnc_pkg;

  localparam int MAX_WIDTH  = 1024;
  localparam int MAX_HEIGHT = 1024;

  localparam int COL_W   = $clog2(MAX_WIDTH);
  localparam int EW_W    = $clog2(MAX_WIDTH + 1);
  localparam int EH_W    = $clog2(MAX_HEIGHT + 1);
  // The row position runs one past the last row plus one while the lag drains.
  localparam int ROW_W   = $clog2(MAX_HEIGHT + 2);
  localparam int CFG_W   = 11;
  localparam int LIMIT_W = 4;
  localparam int COUNT_W = 4;
  localparam int TOTAL_W = 21;
  localparam int IDX_W   = 2;
  localparam int LINE_W  = 2;

  localparam logic [TOTAL_W-1:0] TOTAL_MAX = '1;

  localparam logic [CFG_W-1:0]   WIDTH_RESET  = 11'd1024;
  localparam logic [CFG_W-1:0]   HEIGHT_RESET = 11'd1024;
  localparam logic [LIMIT_W-1:0] LIMIT_RESET  = 4'd4;

  localparam logic [IDX_W-1:0] CFG_GRID_WIDTH     = 2'd0;
  localparam logic [IDX_W-1:0] CFG_GRID_HEIGHT    = 2'd1;
  localparam logic [IDX_W-1:0] CFG_NEIGHBOR_LIMIT = 2'd2;

  localparam logic OP_CELL  = 1'b0;
  localparam logic OP_FLUSH = 1'b1;

  typedef struct packed {
    logic op;
    logic occupied;
  } in_item_t;

  typedef struct packed {
    logic                 center_occupied;
    logic [COUNT_W-1:0]   neighbor_count;
    logic                 marked;
    logic [TOTAL_W-1:0]   marked_total;
    logic                 last;
  } out_item_t;

  // Position-derived control for one beat, handed from the raster tracker
  // to the window evaluator.
  typedef struct packed {
    logic [COL_W-1:0] col;
    logic             v;
    logic             emit;
    logic             r_ge1;
    logic             r_ge2;
    logic             left_zero;
    logic             right_zero;
    logic             last;
  } pos_info_t;

endpackage

// ===== rtl/core/gnc_line_ram.sv =====
// ----------------------------------------------------------------------------
// gnc_line_ram
// Two line buffers in one synchronous RAM: bit 0 holds the row above,
// bit 1 the row two above. One write and one registered read per cycle.
// ----------------------------------------------------------------------------
module gnc_line_ram
  import gnc_pkg::*;
(
  input  logic              clk,
  input  logic              we,
  input  logic [COL_W-1:0]  waddr,
  input  logic [LINE_W-1:0] wdata,
  input  logic              re,
  input  logic [COL_W-1:0]  raddr,
  output logic [LINE_W-1:0] rdata
);

  logic [LINE_W-1:0] mem [MAX_WIDTH];
  logic [LINE_W-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

// ===== rtl/core/gnc_raster.sv =====
// ----------------------------------------------------------------------------
// gnc_raster
// Column and row tracker. Derives the per-beat masking, edge and emit
// flags from the current raster position.
// ----------------------------------------------------------------------------
module gnc_raster
  import gnc_pkg::*;
(
  input  logic            clk,
  input  logic            rst_n,
  input  logic            advance,
  input  logic            restart,
  input  logic [EW_W-1:0] w_eff,
  input  logic [EH_W-1:0] h_eff,
  input  in_item_t        item,
  output pos_info_t       info
);

  logic [COL_W-1:0] c_r, c_nxt;
  logic [ROW_W-1:0] r_r, r_nxt;
  logic [COL_W:0]   c_inc;
  logic [ROW_W-1:0] h_row;

  assign c_inc = {1'b0, c_r} + (COL_W + 1)'(1);
  assign h_row = ROW_W'(h_eff);

  always_comb begin
    info.col        = c_r;
    info.v          = (item.op == OP_CELL) && item.occupied && (r_r < h_row);
    info.r_ge1      = (r_r >= ROW_W'(1));
    info.r_ge2      = (r_r >= ROW_W'(2));
    info.emit       = (c_r == '0) ? info.r_ge2 : info.r_ge1;
    // At column zero the evaluated center is the last column of the row above.
    info.right_zero = (c_r == '0);
    info.left_zero  = (c_r == '0) ? (w_eff == EW_W'(1)) : (c_r == COL_W'(1));
    info.last       = (c_r == '0) && (r_r == h_row + ROW_W'(1));
  end

  always_comb begin
    c_nxt = c_r;
    r_nxt = r_r;
    if (restart || (advance && info.last)) begin
      c_nxt = '0;
      r_nxt = '0;
    end else if (advance) begin
      if (c_inc >= (COL_W + 1)'(w_eff)) begin
        c_nxt = '0;
        r_nxt = r_r + ROW_W'(1);
      end else begin
        c_nxt = c_inc[COL_W-1:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      c_r <= '0;
      r_r <= '0;
    end else begin
      c_r <= c_nxt;
      r_r <= r_nxt;
    end
  end

endmodule

// ===== rtl/core/gnc_window.sv =====
// ----------------------------------------------------------------------------
// gnc_window
// 3x3 window evaluator: builds the new column from the line buffer data,
// counts the neighbors of the center and keeps the running total.
// ----------------------------------------------------------------------------
module gnc_window
  import gnc_pkg::*;
(
  input  logic               clk,
  input  logic               rst_n,
  input  logic               go,
  input  logic               restart,
  input  pos_info_t          info,
  input  logic [LINE_W-1:0]  line_rd,
  input  logic [LIMIT_W-1:0] limit,
  output logic [LINE_W-1:0]  line_wr,
  output out_item_t          result
);

  // Column bits: 0 top, 1 middle, 2 bottom.
  logic [2:0]         win1_r, win1_nxt;
  logic [2:0]         win2_r, win2_nxt;
  logic [TOTAL_W-1:0] total_r, total_nxt;
  logic [2:0]         newcol, left, right;
  logic [COUNT_W-1:0] count;
  logic               mark;
  logic [TOTAL_W-1:0] total_upd;

  assign newcol  = {info.v, info.r_ge1 & line_rd[0], info.r_ge2 & line_rd[1]};
  // The row above moves down to become the row two above.
  assign line_wr = {line_rd[0], info.v};

  assign left  = info.left_zero  ? 3'b000 : win1_r;
  assign right = info.right_zero ? 3'b000 : newcol;

  always_comb begin
    count = COUNT_W'(left[0]) + COUNT_W'(left[1]) + COUNT_W'(left[2])
          + COUNT_W'(right[0]) + COUNT_W'(right[1]) + COUNT_W'(right[2])
          + COUNT_W'(win2_r[0]) + COUNT_W'(win2_r[2]);
    mark      = win2_r[1] && (count < limit);
    total_upd = (mark && (total_r != TOTAL_MAX)) ? total_r + TOTAL_W'(1) : total_r;
  end

  always_comb begin
    result.center_occupied = win2_r[1];
    result.neighbor_count  = count;
    result.marked          = mark;
    result.marked_total    = total_upd;
    result.last            = info.last;
  end

  always_comb begin
    win1_nxt  = win1_r;
    win2_nxt  = win2_r;
    total_nxt = total_r;
    if (restart || (go && info.emit && info.last)) begin
      win1_nxt  = '0;
      win2_nxt  = '0;
      total_nxt = '0;
    end else if (go) begin
      win1_nxt = win2_r;
      win2_nxt = newcol;
      if (info.emit) begin
        total_nxt = total_upd;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      win1_r  <= '0;
      win2_r  <= '0;
      total_r <= '0;
    end else begin
      win1_r  <= win1_nxt;
      win2_r  <= win2_nxt;
      total_r <= total_nxt;
    end
  end

endmodule

// ===== rtl/core/grid_neighbor_count_threshold_core.sv =====
// A result is computed in stage 1 and held in the output register; the beat that
// completes its window arrives grid_width+1 beats after the center cell itself.
// Throughput: one beat per cycle while no result is blocked in stage 1, set by the line
// RAM read-modify-write at one column per cycle, forwarding when consecutive beats share a column.
// Reset clears positions, window, total and handshake state; the line RAM is not
// cleared, since rows above the grid are masked on read.
// ----------------------------------------------------------------------------
// grid_neighbor_count_threshold_core
// Streaming 3x3 neighbor count with threshold marking and a running total.
// ----------------------------------------------------------------------------
module grid_neighbor_count_threshold_core
  import gnc_pkg::*;
(
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  output logic             in_ready,
  input  in_item_t         in_data,
  output logic             out_valid,
  input  logic             out_ready,
  output out_item_t        out_data,
  input  logic             cfg_wr_en,
  input  logic [IDX_W-1:0] cfg_index,
  input  logic [CFG_W-1:0] cfg_wdata
);

  logic [CFG_W-1:0]   grid_width_r, grid_width_nxt;
  logic [CFG_W-1:0]   grid_height_r, grid_height_nxt;
  logic [LIMIT_W-1:0] limit_r, limit_nxt;
  logic               cfg_hit;
  logic [EW_W-1:0]    w_eff;
  logic [EH_W-1:0]    h_eff;

  logic               accept;
  logic               s1_go;
  logic               s1_valid_r, s1_valid_nxt;
  pos_info_t          s1_info_r;
  pos_info_t          pos_info;
  logic               fwd_hit_r;
  logic [LINE_W-1:0]  fwd_data_r;
  logic [LINE_W-1:0]  ram_rdata;
  logic [LINE_W-1:0]  line_rd;
  logic [LINE_W-1:0]  line_wr;
  out_item_t          result;
  logic               out_valid_r, out_valid_nxt;
  out_item_t          out_r;

  // Configuration registers.
  always_comb begin
    grid_width_nxt  = grid_width_r;
    grid_height_nxt = grid_height_r;
    limit_nxt       = limit_r;
    cfg_hit         = 1'b0;
    if (cfg_wr_en) begin
      case (cfg_index)
        CFG_GRID_WIDTH: begin
          grid_width_nxt = cfg_wdata;
          cfg_hit        = 1'b1;
        end
        CFG_GRID_HEIGHT: begin
          grid_height_nxt = cfg_wdata;
          cfg_hit         = 1'b1;
        end
        CFG_NEIGHBOR_LIMIT: begin
          limit_nxt = cfg_wdata[LIMIT_W-1:0];
          cfg_hit   = 1'b1;
        end
        default: cfg_hit = 1'b0;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      grid_width_r  <= WIDTH_RESET;
      grid_height_r <= HEIGHT_RESET;
      limit_r       <= LIMIT_RESET;
    end else begin
      grid_width_r  <= grid_width_nxt;
      grid_height_r <= grid_height_nxt;
      limit_r       <= limit_nxt;
    end
  end

  // A zero dimension is taken as one, anything above the maximum as the maximum.
  always_comb begin
    if (grid_width_r == '0) begin
      w_eff = EW_W'(1);
    end else if (32'(grid_width_r) > 32'(MAX_WIDTH)) begin
      w_eff = EW_W'(MAX_WIDTH);
    end else begin
      w_eff = EW_W'(grid_width_r);
    end
    if (grid_height_r == '0) begin
      h_eff = EH_W'(1);
    end else if (32'(grid_height_r) > 32'(MAX_HEIGHT)) begin
      h_eff = EH_W'(MAX_HEIGHT);
    end else begin
      h_eff = EH_W'(grid_height_r);
    end
  end

  // Handshake. Beats that produce no result pass stage 1 even when the
  // output register is blocked.
  assign s1_go    = s1_valid_r && (!s1_info_r.emit || !out_valid_r || out_ready);
  assign in_ready = !s1_valid_r || s1_go;
  assign accept   = in_valid && in_ready;

  assign s1_valid_nxt  = accept ? 1'b1 : (s1_go ? 1'b0 : s1_valid_r);
  assign out_valid_nxt = (s1_go && s1_info_r.emit) ? 1'b1 :
                         (out_ready ? 1'b0 : out_valid_r);

  gnc_raster u_raster (
    .clk     (clk),
    .rst_n   (rst_n),
    .advance (accept),
    .restart (cfg_hit),
    .w_eff   (w_eff),
    .h_eff   (h_eff),
    .item    (in_data),
    .info    (pos_info)
  );

  gnc_line_ram u_line_ram (
    .clk   (clk),
    .we    (s1_go),
    .waddr (s1_info_r.col),
    .wdata (line_wr),
    .re    (accept),
    .raddr (pos_info.col),
    .rdata (ram_rdata)
  );

  // The RAM returns old data when the beat in stage 1 writes the column
  // being read in the same cycle, so that write is forwarded.
  always_ff @(posedge clk) begin
    if (accept) begin
      fwd_data_r <= line_wr;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fwd_hit_r <= 1'b0;
    end else if (accept) begin
      fwd_hit_r <= s1_go && (s1_info_r.col == pos_info.col);
    end
  end

  assign line_rd = fwd_hit_r ? fwd_data_r : ram_rdata;

  gnc_window u_window (
    .clk     (clk),
    .rst_n   (rst_n),
    .go      (s1_go),
    .restart (cfg_hit),
    .info    (s1_info_r),
    .line_rd (line_rd),
    .limit   (limit_r),
    .line_wr (line_wr),
    .result  (result)
  );

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_info_r <= pos_info;
    end
    if (s1_go && s1_info_r.emit) begin
      out_r <= result;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      s1_valid_r  <= s1_valid_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

`ifndef SYNTHESIS
  a_s1_hold: assert property (@(posedge clk) disable iff (!rst_n)
    s1_valid_r && !s1_go |=> s1_valid_r && $stable(s1_info_r))
    else $error("stage 1 beat lost or changed while stalled");

  a_no_overrun: assert property (@(posedge clk) disable iff (!rst_n)
    s1_valid_r && s1_info_r.emit && out_valid_r && !out_ready |-> !in_ready)
    else $error("input accepted while a result is blocked in stage 1");

  a_col_range: assert property (@(posedge clk) disable iff (!rst_n)
    32'(pos_info.col) < 32'(w_eff))
    else $error("column position outside the grid width");

  a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> out_r.neighbor_count <= COUNT_W'(8))
    else $error("neighbor count above eight");

  a_mark_center: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_r.marked |-> out_r.center_occupied)
    else $error("empty center marked");
`endif

endmodule

// ===== bench/testbench.sv =====
// ----------------------------------------------------------------------------
// testbench
// Checks the streaming 3x3 neighbor count block. A short table of directed
// beats comes first. Random grids of many shapes and thresholds follow, some
// of them cut off part way. Each result is compared against its table entry where
// one is given, else against a cycle-free model of the line buffers and window kept
// in the bench, with random idling on both channels.
// ----------------------------------------------------------------------------
module testbench;
  import gnc_pkg::*;

  localparam logic [IDX_W-1:0] CFG_UNUSED = 2'd3;
  localparam int SETTLE_CYCLES = 8;
  localparam int QUIET_LIMIT   = 4000;
  localparam int LONG_HOLD     = 400;
  localparam int RANDOM_BEATS  = 560;
  localparam int CUT_BEATS     = 40;

  typedef enum logic {ROW_WRITE, ROW_BEAT} row_kind_t;

  typedef struct {
    row_kind_t        kind;
    logic [IDX_W-1:0] idx;
    logic [CFG_W-1:0] val;
    in_item_t         beat;
    bit               typed;
    out_item_t        want;
  } plan_row_t;

  logic             clk;
  logic             rst_n;
  logic             in_valid;
  logic             in_ready;
  in_item_t         in_data;
  logic             out_valid;
  logic             out_ready;
  out_item_t        out_data;
  logic             cfg_wr_en;
  logic [IDX_W-1:0] cfg_index;
  logic [CFG_W-1:0] cfg_wdata;

  grid_neighbor_count_threshold_core dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .cfg_wr_en (cfg_wr_en),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  // Bench copy of the block state.
  logic [CFG_W-1:0]   grid_w_q;
  logic [CFG_W-1:0]   grid_h_q;
  logic [LIMIT_W-1:0] limit_q;
  logic               line_up1 [MAX_WIDTH];
  logic               line_up2 [MAX_WIDTH];
  logic [2:0]         win [3];
  int unsigned        col_pos;
  int unsigned        row_pos;
  int unsigned        mark_sum;

  out_item_t   pending_counts[$];
  out_item_t   due;
  plan_row_t   plan[$];
  int unsigned mismatches = 0;
  int unsigned out_beats = 0;
  int unsigned rand_beats;
  int unsigned quiet = 0;
  int unsigned hold_req;
  bit          calm_tx;
  bit          calm_rx;

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  function automatic int unsigned clamp_dim(input logic [CFG_W-1:0] v, input int unsigned top);
    if (v == 0) return 1;
    if (v > top) return top;
    return v;
  endfunction

  function automatic void restart_grid();
    col_pos  = 0;
    row_pos  = 0;
    mark_sum = 0;
    for (int k = 0; k < 3; k++) win[k] = '0;
  endfunction

  function automatic void apply_register(input logic [IDX_W-1:0] idx,
                                         input logic [CFG_W-1:0] val);
    case (idx)
      CFG_GRID_WIDTH:     grid_w_q = val;
      CFG_GRID_HEIGHT:    grid_h_q = val;
      CFG_NEIGHBOR_LIMIT: limit_q  = val[LIMIT_W-1:0];
      default:            return;
    endcase
    restart_grid();
  endfunction

  // Advances the line buffers and window by one beat; returns 1 when the
  // beat completes the window of a grid cell.
  function automatic bit advance_stencil(input in_item_t it, output out_item_t res);
    int unsigned w, h, c, r, cc, rc, cnt;
    logic        v, top, mid;
    logic [2:0]  newcol, lft, ctr, rgt;
    bit          emit, fin, mark;
    w = clamp_dim(grid_w_q, MAX_WIDTH);
    h = clamp_dim(grid_h_q, MAX_HEIGHT);
    c = (col_pos >= w) ? 0 : col_pos;
    r = row_pos;
    res = '0;
    // Anything past the last row behaves as an empty cell.
    v = (it.op == OP_CELL) && it.occupied && (r < h);
    top = (r >= 2) ? line_up2[c] : 1'b0;
    mid = (r >= 1) ? line_up1[c] : 1'b0;
    line_up2[c] = line_up1[c];
    line_up1[c] = v;
    newcol = {v, mid, top};
    lft = win[1];
    ctr = win[2];
    rgt = newcol;
    if (c == 0) begin
      emit = (r >= 2);
      rc = r - 2;
      cc = w - 1;
    end else begin
      emit = (r >= 1);
      rc = r - 1;
      cc = c - 1;
    end
    if (cc == 0) lft = '0;
    if (cc == w - 1) rgt = '0;
    win[0] = win[1];
    win[1] = win[2];
    win[2] = newcol;
    c++;
    if (c >= w) begin
      c = 0;
      r++;
    end
    col_pos = c;
    row_pos = r;
    if (!emit) return 0;
    cnt = lft[0] + lft[1] + lft[2] + rgt[0] + rgt[1] + rgt[2] + ctr[0] + ctr[2];
    mark = ctr[1] && (cnt < limit_q);
    if (mark && mark_sum < TOTAL_MAX) mark_sum++;
    fin = (rc == h - 1) && (cc == w - 1);
    res.center_occupied = ctr[1];
    res.neighbor_count  = cnt[COUNT_W-1:0];
    res.marked          = mark;
    res.marked_total    = mark_sum[TOTAL_W-1:0];
    res.last            = fin;
    if (fin) restart_grid();
    return 1;
  endfunction

  function automatic out_item_t mk_result(input logic ctr, input logic [COUNT_W-1:0] cnt,
                                          input logic mark, input logic [TOTAL_W-1:0] total,
                                          input logic fin);
    out_item_t res;
    res.center_occupied = ctr;
    res.neighbor_count  = cnt;
    res.marked          = mark;
    res.marked_total    = total;
    res.last            = fin;
    return res;
  endfunction

  function automatic plan_row_t write_row(input logic [IDX_W-1:0] idx,
                                          input logic [CFG_W-1:0] val);
    plan_row_t row;
    row.kind  = ROW_WRITE;
    row.idx   = idx;
    row.val   = val;
    row.beat  = '0;
    row.typed = 1'b0;
    row.want  = '0;
    return row;
  endfunction

  function automatic plan_row_t beat_row(input logic op, input logic occ);
    plan_row_t row;
    row = write_row(CFG_GRID_WIDTH, '0);
    row.kind          = ROW_BEAT;
    row.beat.op       = op;
    row.beat.occupied = occ;
    return row;
  endfunction

  function automatic plan_row_t typed_row(input logic op, input logic occ,
                                          input out_item_t want);
    plan_row_t row;
    row = beat_row(op, occ);
    row.typed = 1'b1;
    row.want  = want;
    return row;
  endfunction

  task automatic check_field(input string name, input logic [31:0] exp_v,
                             input logic [31:0] act_v);
    if (exp_v !== act_v) begin
      mismatches++;
      $display("%0t: %s expected %0d, got %0d", $time, name, exp_v, act_v);
    end
  endtask

  // Result monitor.
  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) begin
      out_beats++;
      if (pending_counts.size() == 0) begin
        mismatches++;
        $display("%0t: result with nothing expected, expected none, got %h", $time, out_data);
      end else begin
        due = pending_counts.pop_front();
        check_field("center_occupied", due.center_occupied, out_data.center_occupied);
        check_field("neighbor_count", due.neighbor_count, out_data.neighbor_count);
        check_field("marked", due.marked, out_data.marked);
        check_field("marked_total", due.marked_total, out_data.marked_total);
        check_field("last", due.last, out_data.last);
      end
    end
  end

  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_valid && in_ready) || (out_valid && out_ready)) quiet = 0;
      else quiet++;
      if (quiet >= QUIET_LIMIT) begin
        $display("FAILED: results differ");
        $finish;
      end
    end
  end

  // Receiver: after each result beat it draws a pause, and a hold request
  // from the stimulus side turns into one long stall.
  initial begin : receiver
    int unsigned seen;
    int unsigned holds_done;
    int unsigned rx_gap;
    seen = 0;
    holds_done = 0;
    rx_gap = 0;
    out_ready = 1'b0;
    forever begin
      @(negedge clk);
      if (holds_done != hold_req) begin
        holds_done = hold_req;
        seen = out_beats;
        rx_gap = LONG_HOLD;
      end else if (seen != out_beats) begin
        seen = out_beats;
        rx_gap = calm_rx ? 0 : $urandom_range(0, 11);
      end
      if (rx_gap > 0) begin
        out_ready <= 1'b0;
        rx_gap--;
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  task automatic push_beat(input in_item_t it, input bit typed, input out_item_t want);
    int unsigned gap;
    out_item_t   res;
    gap = calm_tx ? 0 : $urandom_range(0, 11);
    @(negedge clk);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= it;
    do @(posedge clk); while (!in_ready);
    if (advance_stencil(it, res)) pending_counts.push_back(typed ? want : res);
  endtask

  // Stops offering beats and waits until every expected result is out.
  task automatic settle();
    @(negedge clk);
    in_valid <= 1'b0;
    while (pending_counts.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic cfg_write(input logic [IDX_W-1:0] idx, input logic [CFG_W-1:0] val);
    @(negedge clk);
    cfg_wr_en <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    @(posedge clk);
    apply_register(idx, val);
    @(negedge clk);
    cfg_wr_en <= 1'b0;
  endtask

  // Sends one grid with its flush tail; a broken grid stops at a random
  // point and is left for the next register write to discard.
  task automatic run_grid(input bit broken);
    int unsigned w, h, cells, total, stop, pause_at, dens;
    in_item_t    it;
    w = clamp_dim(grid_w_q, MAX_WIDTH);
    h = clamp_dim(grid_h_q, MAX_HEIGHT);
    cells = w * h;
    total = cells + w + 1;
    stop = broken ? $urandom_range(1, total - 1) : total;
    pause_at = ($urandom_range(0, 3) == 0) ? $urandom_range(0, stop - 1) : stop;
    dens = ($urandom_range(0, 4) == 0) ? 100 : $urandom_range(10, 90);
    for (int unsigned i = 0; i < stop; i++) begin
      if (i == pause_at) settle();
      if (i < cells) begin
        it.op = ($urandom_range(0, 11) == 0) ? OP_FLUSH : OP_CELL;
        it.occupied = ($urandom_range(0, 99) < dens);
      end else begin
        it.op = 1'($urandom_range(0, 1));
        it.occupied = 1'($urandom_range(0, 1));
      end
      push_beat(it, 1'b0, '0);
      rand_beats++;
    end
  endtask

  task automatic run_phase(input logic [CFG_W-1:0] wv, input logic [CFG_W-1:0] hv,
                           input logic [LIMIT_W-1:0] lv, input int unsigned grids,
                           input bit may_break, input bit steady);
    settle();
    cfg_write(CFG_GRID_WIDTH, wv);
    cfg_write(CFG_GRID_HEIGHT, hv);
    cfg_write(CFG_NEIGHBOR_LIMIT, lv);
    calm_tx = steady || ($urandom_range(0, 3) == 0);
    calm_rx = ($urandom_range(0, 3) == 0);
    if (steady) hold_req++;
    for (int unsigned g = 0; g < grids; g++)
      run_grid(may_break && g == grids - 1 && $urandom_range(0, 3) == 0);
    settle();
  endtask

  // Sends the first beats of a large grid; the next register write discards
  // the rest.
  task automatic run_cut(input logic [CFG_W-1:0] wv, input logic [CFG_W-1:0] hv,
                         input logic [LIMIT_W-1:0] lv, input int unsigned beats);
    in_item_t it;
    settle();
    cfg_write(CFG_GRID_WIDTH, wv);
    cfg_write(CFG_GRID_HEIGHT, hv);
    cfg_write(CFG_NEIGHBOR_LIMIT, lv);
    calm_tx = 1'b0;
    calm_rx = 1'b0;
    for (int unsigned i = 0; i < beats; i++) begin
      it.op = OP_CELL;
      it.occupied = 1'($urandom_range(0, 1));
      push_beat(it, 1'b0, '0);
    end
    settle();
  endtask

  function automatic logic [CFG_W-1:0] pick_dim();
    if ($urandom_range(0, 9) == 0) return '0;
    return CFG_W'($urandom_range(1, 8));
  endfunction

  initial begin : stimulus
    int unsigned phase_no;
    rst_n      = 1'b0;
    in_valid   = 1'b0;
    in_data    = '0;
    cfg_wr_en  = 1'b0;
    cfg_index  = '0;
    cfg_wdata  = '0;
    calm_tx    = 1'b0;
    calm_rx    = 1'b0;
    hold_req   = 0;
    rand_beats = 0;
    grid_w_q   = WIDTH_RESET;
    grid_h_q   = HEIGHT_RESET;
    limit_q    = LIMIT_RESET;
    for (int k = 0; k < MAX_WIDTH; k++) begin
      line_up1[k] = 1'b0;
      line_up2[k] = 1'b0;
    end
    restart_grid();

    // Zero width and height are taken as one: a lone cell with no neighbors.
    plan.push_back(write_row(CFG_GRID_WIDTH, 11'd0));
    plan.push_back(write_row(CFG_GRID_HEIGHT, 11'd0));
    plan.push_back(write_row(CFG_NEIGHBOR_LIMIT, 11'd4));
    plan.push_back(beat_row(OP_CELL, 1'b1));
    plan.push_back(beat_row(OP_FLUSH, 1'b0));
    plan.push_back(typed_row(OP_FLUSH, 1'b1, mk_result(1'b1, 4'd0, 1'b1, 21'd1, 1'b1)));
    // A limit of zero marks nothing.
    plan.push_back(write_row(CFG_NEIGHBOR_LIMIT, 11'd0));
    plan.push_back(beat_row(OP_CELL, 1'b1));
    plan.push_back(beat_row(OP_FLUSH, 1'b1));
    plan.push_back(typed_row(OP_FLUSH, 1'b0, mk_result(1'b1, 4'd0, 1'b0, 21'd0, 1'b1)));
    // Limit above eight; occupied cells after the last row count as empty.
    plan.push_back(write_row(CFG_NEIGHBOR_LIMIT, 11'd9));
    plan.push_back(beat_row(OP_CELL, 1'b1));
    plan.push_back(beat_row(OP_CELL, 1'b1));
    plan.push_back(typed_row(OP_CELL, 1'b0, mk_result(1'b1, 4'd0, 1'b1, 21'd1, 1'b1)));
    // The spare index must be ignored, then a full 3x3 grid whose center is
    // a flush beat.
    plan.push_back(write_row(CFG_UNUSED, 11'h7ff));
    plan.push_back(write_row(CFG_GRID_WIDTH, 11'd3));
    plan.push_back(write_row(CFG_GRID_HEIGHT, 11'd3));
    plan.push_back(write_row(CFG_NEIGHBOR_LIMIT, 11'd4));
    for (int i = 0; i < 9; i++) plan.push_back(beat_row((i == 4) ? OP_FLUSH : OP_CELL, 1'b1));
    for (int i = 0; i < 4; i++) plan.push_back(beat_row(OP_FLUSH, i[0]));

    repeat (11) @(negedge clk);
    rst_n <= 1'b1;

    foreach (plan[i]) begin
      if (plan[i].kind == ROW_WRITE) begin
        settle();
        cfg_write(plan[i].idx, plan[i].val);
      end else begin
        push_beat(plan[i].beat, plan[i].typed, plan[i].want);
      end
    end

    rand_beats = 0;
    phase_no = 0;
    while (rand_beats < RANDOM_BEATS) begin
      // One phase runs steady against a long receiver stall to fill the block.
      if (phase_no == 2) run_phase(11'd4, 11'd8, LIMIT_W'($urandom_range(0, 15)), 1, 1'b0,
                                   1'b1);
      else run_phase(pick_dim(), pick_dim(), LIMIT_W'($urandom_range(0, 15)),
                     $urandom_range(1, 3), 1'b1, 1'b0);
      phase_no++;
    end
    // Oversized width and height clamp to the maximum.
    run_cut(11'h401, 11'd1, 4'd15, CUT_BEATS);
    run_cut(11'd1, 11'h401, 4'd5, CUT_BEATS);
    settle();

    if (mismatches == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

endmodule
